FILE: rtl/dhst_pkg.sv
package dhst_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_KEY_LEN_DEF = 32;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int          HASH_W     = 32;
    localparam logic [31:0] HASH_INIT  = 32'd5381;
    localparam int          CFG_W      = 9;
    localparam logic [8:0]  SIZE_RESET = 9'd251;
    localparam int          SIZE_MIN   = 3;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    // classification of one complete key, handed from front to back
    typedef struct packed {
        logic              mode;
        logic              overflow;
        logic [HASH_W-1:0] hash;
    } job_t;

endpackage

FILE: rtl/dhst_queue.sv
module dhst_queue #(
    parameter int MAX_KEY_LEN = dhst_pkg::MAX_KEY_LEN_DEF,
    parameter int DATA_WIDTH  = dhst_pkg::DATA_WIDTH_DEF,
    parameter int LW          = 6,
    parameter int KW          = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_we,
    input  logic [KW-1:0]         char_idx,
    input  logic [7:0]            char_val,
    input  logic                  push,
    input  dhst_pkg::job_t        push_job,
    input  logic [LW-1:0]         push_len,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  empty,
    output dhst_pkg::job_t        head_job,
    output logic [LW-1:0]         head_len,
    output logic [DATA_WIDTH-1:0] head_data,
    input  logic                  pop,
    input  logic [KW-1:0]         rd_idx,
    output logic [7:0]            rd_char
);
    import dhst_pkg::*;

    logic [7:0]            key0_reg [MAX_KEY_LEN];
    logic [7:0]            key1_reg [MAX_KEY_LEN];
    job_t                  job_reg  [2];
    logic [LW-1:0]         len_reg  [2];
    logic [DATA_WIDTH-1:0] data_reg [2];
    logic                  wptr_reg, wptr_next;
    logic                  rptr_reg, rptr_next;
    logic [1:0]            cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    // hold key characters in the bank at the write pointer
    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            if (wptr_reg)
            begin
                key1_reg[char_idx] <= char_val;
            end
            else
            begin
                key0_reg[char_idx] <= char_val;
            end
        end
        if (push)
        begin
            job_reg[wptr_reg]  <= push_job;
            len_reg[wptr_reg]  <= push_len;
            data_reg[wptr_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign head_job  = job_reg[rptr_reg];
    assign head_len  = len_reg[rptr_reg];
    assign head_data = data_reg[rptr_reg];
    assign rd_char   = rptr_reg ? key1_reg[rd_idx] : key0_reg[rd_idx];

endmodule

FILE: rtl/dhst_front.sv
module dhst_front #(
    parameter int MAX_KEY_LEN = dhst_pkg::MAX_KEY_LEN_DEF,
    parameter int DATA_WIDTH  = dhst_pkg::DATA_WIDTH_DEF,
    parameter int LW          = 6,
    parameter int KW          = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  full,
    input  logic                  mode,
    input  logic [7:0]            key_char,
    input  logic                  key_last,
    input  logic [DATA_WIDTH-1:0] data_value,
    output logic                  char_we,
    output logic [KW-1:0]         char_idx,
    output logic [7:0]            char_val,
    output logic                  push,
    output dhst_pkg::job_t        push_job,
    output logic [LW-1:0]         push_len,
    output logic [DATA_WIDTH-1:0] push_data
);
    import dhst_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              accept;
    logic              room;
    logic [HASH_W-1:0] hash_upd;
    logic [LW-1:0]     len_upd;
    logic              ovf_upd;

    assign accept   = start && !full;
    assign room     = (len_reg < LW'(MAX_KEY_LEN));
    assign hash_upd = (hash_reg << 5) + hash_reg + HASH_W'(key_char);
    assign len_upd  = room ? len_reg + LW'(1) : len_reg;
    assign ovf_upd  = ovf_reg || !room;

    // store the character while the key still fits
    assign char_we  = accept && room;
    assign char_idx = len_reg[KW-1:0];
    assign char_val = key_char;

    // hand the finished key over on its last character
    assign push           = accept && key_last;
    assign push_job.mode     = mode;
    assign push_job.overflow = ovf_upd;
    assign push_job.hash     = hash_upd;
    assign push_len       = len_upd;
    assign push_data      = data_value;

    always_comb
    begin
        hash_next = hash_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        if (accept)
        begin
            if (key_last)
            begin
                hash_next = HASH_INIT;
                len_next  = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                hash_next = hash_upd;
                len_next  = len_upd;
                ovf_next  = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_INIT;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: rtl/dhst_back.sv
module dhst_back #(
    parameter int TABLE_DEPTH = dhst_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_LEN = dhst_pkg::MAX_KEY_LEN_DEF,
    parameter int DATA_WIDTH  = dhst_pkg::DATA_WIDTH_DEF,
    parameter int LW          = 6,
    parameter int KW          = 5,
    parameter int SW          = 8,
    parameter int SZW         = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SZW-1:0]        size,
    input  logic                  empty,
    input  dhst_pkg::job_t        head_job,
    input  logic [LW-1:0]         head_len,
    input  logic [DATA_WIDTH-1:0] head_data,
    output logic                  pop,
    output logic [KW-1:0]         key_idx,
    input  logic [7:0]            key_in,
    output logic                  result_valid,
    output dhst_pkg::status_t     status,
    output logic [DATA_WIDTH-1:0] found_data
);
    import dhst_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIV   = 11'b00000000010,
        S_DEC   = 11'b00000000100,
        S_PROBE = 11'b00000001000,
        S_LEN   = 11'b00000010000,
        S_CRD   = 11'b00000100000,
        S_CCHK  = 11'b00001000000,
        S_DATA  = 11'b00010000000,
        S_INS   = 11'b00100000000,
        S_COPY  = 11'b01000000000,
        S_SPARE = 11'b10000000000
    } state_t;

    // table memories
    logic [7:0]            char_mem [TABLE_DEPTH << KW];
    logic [LW-1:0]         len_mem  [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] data_mem [TABLE_DEPTH];
    logic [7:0]            char_q;
    logic [LW-1:0]         len_q;
    logic [DATA_WIDTH-1:0] data_q;

    state_t                state_reg, state_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [SZW-1:0]        count_reg, count_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [4:0]            bit_reg, bit_next;
    logic [SZW-1:0]        r1_reg, r1_next;
    logic [SZW-1:0]        r2_reg, r2_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic [SZW-1:0]        k_reg, k_next;
    logic [LW-1:0]         ci_reg, ci_next;
    logic                  res_valid_reg, res_valid_next;
    status_t               res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;

    logic [SZW:0]          t1, t2;
    logic [SZW-1:0]        size_m1;
    logic [SW-1:0]         start_slot;
    logic [SZW-1:0]        step_val;
    logic [SZW:0]          step_sum;
    logic [SW-1:0]         idx_adv;
    logic                  walk_done;
    logic [SZW+1:0]        load_lhs, load_rhs;
    logic                  too_full;
    logic                  char_we;
    logic                  slot_we;

    assign size_m1    = size - SZW'(1);
    assign t1         = {r1_reg, hash_reg[HASH_W-1]};
    assign t2         = {r2_reg, hash_reg[HASH_W-1]};
    assign start_slot = r1_reg[SW-1:0];
    assign step_val   = r2_reg + SZW'(1);
    assign step_sum   = (SZW+1)'(idx_reg) + (SZW+1)'(step_val);
    assign idx_adv    = (step_sum >= (SZW+1)'(size)) ? SW'(step_sum - (SZW+1)'(size))
                                                     : SW'(step_sum);
    assign walk_done  = ((k_reg + SZW'(1)) == size);
    assign load_lhs   = {count_reg, 2'b00};
    assign load_rhs   = ((SZW+2)'(size) << 1) + (SZW+2)'(size);
    assign too_full   = (load_lhs > load_rhs);
    assign key_idx    = ci_reg[KW-1:0];

    // read the memories at the current slot every cycle
    always_ff @(posedge clk)
    begin
        char_q <= char_mem[{idx_reg, ci_reg[KW-1:0]}];
        len_q  <= len_mem[idx_reg];
        data_q <= data_mem[idx_reg];
        if (char_we)
        begin
            char_mem[{idx_reg, ci_reg[KW-1:0]}] <= key_in;
        end
        if (slot_we)
        begin
            len_mem[idx_reg]  <= head_len;
            data_mem[idx_reg] <= head_data;
        end
    end

    // sequence one job: remainders, probe walk, key compare, insert
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        hash_next       = hash_reg;
        bit_next        = bit_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        ci_next         = ci_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        pop             = 1'b0;
        char_we         = 1'b0;
        slot_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    hash_next  = head_job.hash;
                    bit_next   = '0;
                    r1_next    = '0;
                    r2_next    = '0;
                    state_next = S_DIV;
                end
            end

            // one bit of both remainders per cycle
            S_DIV:
            begin
                r1_next   = (t1 >= (SZW+1)'(size)) ? SZW'(t1 - (SZW+1)'(size)) : SZW'(t1);
                r2_next   = (t2 >= (SZW+1)'(size_m1)) ? SZW'(t2 - (SZW+1)'(size_m1))
                                                      : SZW'(t2);
                hash_next = hash_reg << 1;
                bit_next  = bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                idx_next = start_slot;
                k_next   = '0;
                if (head_job.overflow || (!head_job.mode && head_data == '0))
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_INVALID;
                    res_data_next   = '0;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (count_reg != '0)
                begin
                    state_next = S_PROBE;
                end
                else if (head_job.mode)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_NOT_FOUND;
                    res_data_next   = '0;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (too_full)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_FULL;
                    res_data_next   = '0;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_INS;
                end
            end

            S_PROBE:
            begin
                if (!used_reg[idx_reg] || (k_reg != '0 && idx_reg == start_slot))
                begin
                    // key absent
                    idx_next = start_slot;
                    k_next   = '0;
                    if (head_job.mode || too_full)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = head_job.mode ? ST_NOT_FOUND : ST_FULL;
                        res_data_next   = '0;
                        pop             = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    state_next = S_LEN;
                end
            end

            S_LEN, S_CCHK:
            begin
                if ((state_reg == S_LEN) ? (len_q != head_len) : (char_q != key_in))
                begin
                    // mismatch: advance along the walk
                    if (walk_done)
                    begin
                        idx_next = start_slot;
                        k_next   = '0;
                        if (head_job.mode || too_full)
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = head_job.mode ? ST_NOT_FOUND : ST_FULL;
                            res_data_next   = '0;
                            pop             = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_adv;
                        k_next     = k_reg + SZW'(1);
                        state_next = S_PROBE;
                    end
                end
                else if ((state_reg == S_LEN && head_len == '0) ||
                         (state_reg == S_CCHK && ci_reg == head_len - LW'(1)))
                begin
                    // match
                    if (head_job.mode)
                    begin
                        state_next = S_DATA;
                    end
                    else
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_DUPLICATE;
                        res_data_next   = '0;
                        pop             = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ci_next    = (state_reg == S_LEN) ? '0 : ci_reg + LW'(1);
                    state_next = S_CRD;
                end
            end

            S_CRD:
            begin
                state_next = S_CCHK;
            end

            S_DATA:
            begin
                res_valid_next  = 1'b1;
                res_status_next = ST_FOUND;
                res_data_next   = data_q;
                pop             = 1'b1;
                state_next      = S_IDLE;
            end

            S_INS:
            begin
                if (!used_reg[idx_reg])
                begin
                    used_next[idx_reg] = 1'b1;
                    slot_we            = 1'b1;
                    count_next         = count_reg + SZW'(1);
                    ci_next            = '0;
                    if (head_len == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_INSERTED;
                        res_data_next   = head_data;
                        pop             = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_COPY;
                    end
                end
                else if (walk_done)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_FULL;
                    res_data_next   = '0;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_adv;
                    k_next   = k_reg + SZW'(1);
                end
            end

            // copy the key into the slot, one character a cycle
            S_COPY:
            begin
                char_we = 1'b1;
                if (ci_reg == head_len - LW'(1))
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_INSERTED;
                    res_data_next   = head_data;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ci_next = ci_reg + LW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg       <= hash_next;
        bit_reg        <= bit_next;
        r1_reg         <= r1_next;
        r2_reg         <= r2_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        ci_reg         <= ci_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign found_data   = res_data_reg;

endmodule

FILE: rtl/double_hash_string_table_top.sv
// String-keyed table with open addressing and double hashing. Send a key one
// character per item (start while busy is low), key_last on its final
// character with mode and data_value. Each character is accepted whenever
// start is high and busy is low; finished keys wait in a two-entry queue while
// the back end works them off. The back end picks a key up, forms both
// remainders one hash bit per cycle and classifies the key before its probe
// walk. The walk compares the stored length and then each character at every
// occupied slot visited, ends at an empty slot, and fetches the data on a hit.
// An insert walks again slot by slot and copies its key at one character per
// cycle. The result is registered from the last of these steps and shows for
// exactly one cycle on result_valid, and cannot be held off. busy is high
// only while two keys are queued. Write table_size through cfg_valid/cfg_data
// only while the block is idle. The table is empty after reset.
module double_hash_string_table_top #(
    parameter int TABLE_DEPTH = dhst_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_LEN = dhst_pkg::MAX_KEY_LEN_DEF,
    parameter int DATA_WIDTH  = dhst_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [7:0]               key_char,
    input  logic                     key_last,
    input  logic [DATA_WIDTH-1:0]    data_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [dhst_pkg::CFG_W-1:0] cfg_data,
    output logic                     result_valid,
    output logic [2:0]               status,
    output logic [DATA_WIDTH-1:0]    found_data
);
    import dhst_pkg::*;

    localparam int LW  = $clog2(MAX_KEY_LEN + 1);
    localparam int KW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int SW  = $clog2(TABLE_DEPTH);
    localparam int SZW = $clog2(TABLE_DEPTH + 1);

    logic [CFG_W-1:0]      table_size_reg;
    logic [31:0]           cfg32;
    logic [SZW-1:0]        eff_size;
    logic                  full;
    logic                  empty;
    logic                  char_we;
    logic [KW-1:0]         char_idx;
    logic [7:0]            char_val;
    logic                  push;
    job_t                  push_job;
    logic [LW-1:0]         push_len;
    logic [DATA_WIDTH-1:0] push_data;
    job_t                  head_job;
    logic [LW-1:0]         head_len;
    logic [DATA_WIDTH-1:0] head_data;
    logic                  pop;
    logic [KW-1:0]         key_idx;
    logic [7:0]            key_rd;
    status_t               res_status;

    // hold the size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            table_size_reg <= cfg_data;
        end
    end

    // clamp the size into the usable range
    assign cfg32 = 32'(table_size_reg);
    always_comb
    begin
        if (cfg32 < 32'(SIZE_MIN))
        begin
            eff_size = SZW'(SIZE_MIN);
        end
        else if (cfg32 > 32'(TABLE_DEPTH))
        begin
            eff_size = SZW'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = SZW'(cfg32);
        end
    end

    assign busy   = full;
    assign status = res_status;

    dhst_front #(
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .DATA_WIDTH  (DATA_WIDTH),
        .LW          (LW),
        .KW          (KW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .full       (full),
        .mode       (mode),
        .key_char   (key_char),
        .key_last   (key_last),
        .data_value (data_value),
        .char_we    (char_we),
        .char_idx   (char_idx),
        .char_val   (char_val),
        .push       (push),
        .push_job   (push_job),
        .push_len   (push_len),
        .push_data  (push_data)
    );

    dhst_queue #(
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .DATA_WIDTH  (DATA_WIDTH),
        .LW          (LW),
        .KW          (KW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_we   (char_we),
        .char_idx  (char_idx),
        .char_val  (char_val),
        .push      (push),
        .push_job  (push_job),
        .push_len  (push_len),
        .push_data (push_data),
        .full      (full),
        .empty     (empty),
        .head_job  (head_job),
        .head_len  (head_len),
        .head_data (head_data),
        .pop       (pop),
        .rd_idx    (key_idx),
        .rd_char   (key_rd)
    );

    dhst_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .DATA_WIDTH  (DATA_WIDTH),
        .LW          (LW),
        .KW          (KW),
        .SW          (SW),
        .SZW         (SZW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .size         (eff_size),
        .empty        (empty),
        .head_job     (head_job),
        .head_len     (head_len),
        .head_data    (head_data),
        .pop          (pop),
        .key_idx      (key_idx),
        .key_in       (key_rd),
        .result_valid (result_valid),
        .status       (res_status),
        .found_data   (found_data)
    );

endmodule
